// ===== hdl/titm_pkg.sv =====
// Package for the trigger/image timestamp matcher.
// Shared types, widths and codes; no dependencies.
package titm_pkg;

    localparam int TS_W        = 63;
    localparam int DELAY_W     = 30;
    localparam int STALE_W     = 5;
    localparam int STALE_MAX   = 31;
    localparam int DELAY_RESET = 58000000;

    // Digit-serial datapath: 4-bit digits over a 64-bit padded word
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 16;
    localparam int SER_W      = DIGIT_W * NUM_DIGITS;
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

    typedef enum logic [2:0] {
        STAT_STORED  = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_MATCHED = 3'd2,
        STAT_EARLY   = 3'd3,
        STAT_EMPTY   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_CMP,
        ST_DONE
    } state_t;

    // Comparator verdict for one image/front pair
    typedef struct packed {
        logic done;   // one-cycle pulse, verdict valid
        logic early;  // image not later than front
        logic over;   // delay above limit (stale)
    } cmp_res_t;

endpackage

// ===== hdl/titm_in_if.sv =====
// Input channel of the timestamp matcher: valid/ready plus the input word.
// Depends on titm_pkg for field widths.
interface titm_in_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [titm_pkg::TS_W-1:0] timestamp_ns;

    modport source (output valid, action, timestamp_ns, input ready);
    modport sink   (input valid, action, timestamp_ns, output ready);
endinterface

// ===== hdl/titm_out_if.sv =====
// Output channel of the timestamp matcher: valid/ready plus the result word.
// Depends on titm_pkg for field widths.
interface titm_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [titm_pkg::TS_W-1:0]    corrected_stamp_ns;
    logic [titm_pkg::STALE_W-1:0] stale_dropped;

    modport source (output valid, status, corrected_stamp_ns, stale_dropped, input ready);
    modport sink   (input valid, status, corrected_stamp_ns, stale_dropped, output ready);
endinterface

// ===== hdl/titm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module titm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/titm_serial_cmp.sv =====
// Digit-serial compare of image time against a queued trigger time.
// Computes diff = ts - front and delay - diff, one 4-bit digit per cycle, LSB first.
// Depends on titm_pkg.
module titm_serial_cmp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [titm_pkg::TS_W-1:0]     ts,
    input  logic [titm_pkg::TS_W-1:0]     front,
    input  logic [titm_pkg::DELAY_W-1:0]  max_delay,
    output titm_pkg::cmp_res_t            res
);

    localparam int SW = titm_pkg::SER_W;
    localparam int DW = titm_pkg::DIGIT_W;
    localparam int CW = titm_pkg::DIG_CNT_W;

    logic [SW-1:0] a_reg, a_next;
    logic [SW-1:0] b_reg, b_next;
    logic [SW-1:0] c_reg, c_next;
    logic          bor1_reg, bor1_next;
    logic          bor2_reg, bor2_next;
    logic          zero_reg, zero_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          early_reg, early_next;
    logic          over_reg, over_next;

    logic [DW:0]   d1;
    logic [DW:0]   d2;

    // one digit of both subtract chains
    always_comb
    begin
        d1 = {1'b0, a_reg[DW-1:0]} - {1'b0, b_reg[DW-1:0]} - {{DW{1'b0}}, bor1_reg};
        d2 = {1'b0, c_reg[DW-1:0]} - {1'b0, d1[DW-1:0]} - {{DW{1'b0}}, bor2_reg};
    end

    // sequencing and shift
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        bor1_next  = bor1_reg;
        bor2_next  = bor2_reg;
        zero_next  = zero_reg;
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        early_next = early_reg;
        over_next  = over_reg;

        if (start)
        begin
            a_next    = {{(SW - titm_pkg::TS_W){1'b0}}, ts};
            b_next    = {{(SW - titm_pkg::TS_W){1'b0}}, front};
            c_next    = {{(SW - titm_pkg::DELAY_W){1'b0}}, max_delay};
            bor1_next = 1'b0;
            bor2_next = 1'b0;
            zero_next = 1'b1;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            a_next    = {{DW{1'b0}}, a_reg[SW-1:DW]};
            b_next    = {{DW{1'b0}}, b_reg[SW-1:DW]};
            c_next    = {{DW{1'b0}}, c_reg[SW-1:DW]};
            bor1_next = d1[DW];
            bor2_next = d2[DW];
            zero_next = zero_reg & (d1[DW-1:0] == '0);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(titm_pkg::NUM_DIGITS - 1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                // borrow out of ts - front, or zero diff: image not later
                early_next = d1[DW] | zero_next;
                over_next  = d2[DW];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        bor1_reg  <= bor1_next;
        bor2_reg  <= bor2_next;
        zero_reg  <= zero_next;
        early_reg <= early_next;
        over_reg  <= over_next;
    end

    assign res.done  = done_reg;
    assign res.early = early_reg;
    assign res.over  = over_reg;

endmodule

// ===== hdl/trigger_image_timestamp_matcher_unit.sv =====
// Top level of the trigger/image timestamp matcher: queue control and result register.
// Depends on titm_pkg, titm_in_if, titm_out_if, titm_ram, titm_serial_cmp.
//
//  Channel     Dir  Handshake         Contents
//  in_word     in   valid/ready       action, timestamp_ns
//  out_word    out  valid/ready       status, corrected_stamp_ns, stale_dropped
//  cfg         in   cfg_we            cfg_wdata = max_delay_ns
//
// Trigger word: taken in the idle state; the done state then loads it into the result register.
// Image word: each queued trigger examined costs a RAM read, a load, a serial subtract
//   over all 16 digits of the 4-bit subtractor and a verdict.
// One word at a time; a new word is taken while the previous result waits.
// A stalled output holds the FSM in its done state until the result register frees.
// Reset empties the queue and loads max_delay_ns = 58000000; no clearing pass.
module trigger_image_timestamp_matcher_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    titm_in_if.sink                          in_word,
    titm_out_if.source                       out_word,
    input  logic                             cfg_we,
    input  logic [titm_pkg::DELAY_W-1:0]     cfg_wdata
);

    localparam int AW  = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);
    localparam int SUW = CNW + 1;
    localparam int TW  = titm_pkg::TS_W;
    localparam int SW  = titm_pkg::STALE_W;

    titm_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CNW-1:0]    count_reg, count_next;
    logic [titm_pkg::DELAY_W-1:0] delay_reg;
    logic [TW-1:0]     ts_reg, ts_next;
    logic [SW-1:0]     stale_reg, stale_next;
    titm_pkg::status_t status_reg, status_next;
    logic [TW-1:0]     stamp_reg, stamp_next;

    logic              out_valid_reg, out_valid_next;
    titm_pkg::status_t out_status_reg, out_status_next;
    logic [TW-1:0]     out_stamp_reg, out_stamp_next;
    logic [SW-1:0]     out_stale_reg, out_stale_next;

    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     tail_addr;
    logic [SUW-1:0]    tail_sum;
    logic [AW-1:0]     head_inc;
    logic [TW-1:0]     ram_rdata;
    logic              cmp_start;
    titm_pkg::cmp_res_t cmp_res;

    // queue storage
    titm_ram #(
        .WIDTH (TW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_addr),
        .wdata (in_word.timestamp_ns),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // delay compare, one digit per cycle
    titm_serial_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmp_start),
        .ts        (ts_reg),
        .front     (ram_rdata),
        .max_delay (delay_reg),
        .res       (cmp_res)
    );

    // circular index arithmetic
    always_comb
    begin
        tail_sum = SUW'(head_reg) + SUW'(count_reg);
        if (tail_sum >= SUW'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SUW'(QUEUE_DEPTH);
        end
        tail_addr = tail_sum[AW-1:0];
        head_inc  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        ts_next         = ts_reg;
        stale_next      = stale_reg;
        status_next     = status_reg;
        stamp_next      = stamp_reg;
        out_valid_next  = out_valid_reg & ~out_word.ready;
        out_status_next = out_status_reg;
        out_stamp_next  = out_stamp_reg;
        out_stale_next  = out_stale_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        cmp_start       = 1'b0;
        in_word.ready   = (state_reg == titm_pkg::ST_IDLE);

        unique case (state_reg)
            titm_pkg::ST_IDLE:
            begin
                if (in_word.valid)
                begin
                    stale_next = '0;
                    stamp_next = '0;
                    ts_next    = in_word.timestamp_ns;
                    if (!in_word.action)
                    begin
                        state_next = titm_pkg::ST_DONE;
                        if (count_reg == CNW'(QUEUE_DEPTH))
                        begin
                            status_next = titm_pkg::STAT_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = titm_pkg::STAT_STORED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = titm_pkg::STAT_EMPTY;
                        state_next  = titm_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = titm_pkg::ST_READ;
                    end
                end
            end
            titm_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = titm_pkg::ST_LOAD;
            end
            titm_pkg::ST_LOAD:
            begin
                cmp_start  = 1'b1;
                state_next = titm_pkg::ST_CMP;
            end
            titm_pkg::ST_CMP:
            begin
                if (cmp_res.done)
                begin
                    if (cmp_res.early)
                    begin
                        status_next = titm_pkg::STAT_EARLY;
                        state_next  = titm_pkg::ST_DONE;
                    end
                    else
                    begin
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                        if (cmp_res.over)
                        begin
                            if (stale_reg != SW'(titm_pkg::STALE_MAX))
                            begin
                                stale_next = stale_reg + 1'b1;
                            end
                            if (count_reg == CNW'(1))
                            begin
                                status_next = titm_pkg::STAT_EMPTY;
                                state_next  = titm_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = titm_pkg::ST_READ;
                            end
                        end
                        else
                        begin
                            status_next = titm_pkg::STAT_MATCHED;
                            stamp_next  = ram_rdata;
                            state_next  = titm_pkg::ST_DONE;
                        end
                    end
                end
            end
            titm_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_word.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_stamp_next  = stamp_reg;
                    out_stale_next  = stale_reg;
                    state_next      = titm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = titm_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= titm_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            delay_reg     <= titm_pkg::DELAY_W'(titm_pkg::DELAY_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ts_reg         <= ts_next;
        stale_reg      <= stale_next;
        status_reg     <= status_next;
        stamp_reg      <= stamp_next;
        out_status_reg <= out_status_next;
        out_stamp_reg  <= out_stamp_next;
        out_stale_reg  <= out_stale_next;
    end

    assign out_word.valid              = out_valid_reg;
    assign out_word.status             = out_status_reg;
    assign out_word.corrected_stamp_ns = out_stamp_reg;
    assign out_word.stale_dropped      = out_stale_reg;

    // queue occupancy stays within bounds
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // a front read is only issued with a trigger queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == titm_pkg::ST_READ) |-> (count_reg != '0))
        else $error("front read with empty queue");

    // comparator verdict only arrives while the FSM waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        cmp_res.done |-> (state_reg == titm_pkg::ST_CMP))
        else $error("unexpected compare verdict");

    // a loaded result overwrites nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == titm_pkg::ST_DONE && out_valid_reg && !out_word.ready)
        |=> (state_reg == titm_pkg::ST_DONE))
        else $error("result lost under stall");

endmodule

// ===== tb/titm_tb_pkg.sv =====
`timescale 1ns / 100ps
// Testbench codes for the timestamp matcher: input action values and timestamp limit.
// Depends on titm_pkg for the timestamp width.
package titm_tb_pkg;

    // Action field of an input word
    localparam logic ACT_TRIGGER = 1'b0;
    localparam logic ACT_IMAGE   = 1'b1;

    // Latest representable time, used to flush the trigger FIFO
    localparam logic [titm_pkg::TS_W-1:0] TS_MAX = {titm_pkg::TS_W{1'b1}};

endpackage

// ===== tb/titm_result_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the timestamp matcher: tracks the trigger FIFO and max_delay_ns,
// predicts one result word per input word and compares. Depends on titm_pkg, titm_tb_pkg.
module titm_result_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    titm_in_if                           in_mon,
    titm_out_if                          out_mon,
    input  logic                         cfg_we,
    input  logic [titm_pkg::DELAY_W-1:0] cfg_wdata,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);

    typedef struct packed {
        titm_pkg::status_t              status;
        logic [titm_pkg::TS_W-1:0]      stamp;
        logic [titm_pkg::STALE_W-1:0]   stale;
    } match_result_t;

    // Shadow copy of the trigger FIFO and the delay limit
    logic [titm_pkg::TS_W-1:0]    trig_fifo [QUEUE_DEPTH];
    int                           trig_head;
    int                           trig_count;
    logic [titm_pkg::DELAY_W-1:0] max_delay;

    match_result_t      expected_q [$];
    int                 fails   = 0;
    int                 checked = 0;

    function automatic void pop_trigger();
        trig_head  = (trig_head + 1) % QUEUE_DEPTH;
        trig_count = trig_count - 1;
    endfunction

    // Result of one input word; updates the shadow FIFO
    function automatic match_result_t match_word(input logic act,
                                                 input logic [titm_pkg::TS_W-1:0] ts);
        match_result_t             r;
        logic [titm_pkg::TS_W-1:0] front;
        bit                        done;
        r.status = titm_pkg::STAT_EMPTY;
        r.stamp  = '0;
        r.stale  = '0;
        done     = 1'b0;
        if (act == titm_tb_pkg::ACT_TRIGGER)
        begin
            if (trig_count >= QUEUE_DEPTH)
            begin
                r.status = titm_pkg::STAT_FULL;
            end
            else
            begin
                trig_fifo[(trig_head + trig_count) % QUEUE_DEPTH] = ts;
                trig_count = trig_count + 1;
                r.status   = titm_pkg::STAT_STORED;
            end
        end
        else
        begin
            // walk the front: stale ones go, then match, early or run dry
            while (!done && trig_count > 0)
            begin
                front = trig_fifo[trig_head];
                if (ts <= front)
                begin
                    r.status = titm_pkg::STAT_EARLY;
                    done     = 1'b1;
                end
                else if ((ts - front) > titm_pkg::TS_W'(max_delay))
                begin
                    pop_trigger();
                    if (r.stale < titm_pkg::STALE_W'(titm_pkg::STALE_MAX))
                        r.stale = r.stale + 1'b1;
                end
                else
                begin
                    r.status = titm_pkg::STAT_MATCHED;
                    r.stamp  = front;
                    pop_trigger();
                    done     = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Compare result words first, then queue the prediction for a new input word
    always @(posedge clk or negedge rst_n)
    begin : monitor
        match_result_t exp_r;
        if (!rst_n)
        begin
            max_delay  = titm_pkg::DELAY_W'(titm_pkg::DELAY_RESET);
            trig_head  = 0;
            trig_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
                max_delay = cfg_wdata;
            if (out_mon.valid && out_mon.ready)
            begin
                checked = checked + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d stamp %0d stale %0d",
                           out_mon.status, out_mon.corrected_stamp_ns, out_mon.stale_dropped);
                    fails = fails + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (out_mon.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.status, out_mon.status);
                        fails = fails + 1;
                    end
                    if (out_mon.corrected_stamp_ns !== exp_r.stamp)
                    begin
                        $error("corrected_stamp_ns: expected %0d, actual %0d",
                               exp_r.stamp, out_mon.corrected_stamp_ns);
                        fails = fails + 1;
                    end
                    if (out_mon.stale_dropped !== exp_r.stale)
                    begin
                        $error("stale_dropped: expected %0d, actual %0d",
                               exp_r.stale, out_mon.stale_dropped);
                        fails = fails + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                expected_q.push_back(match_word(in_mon.action, in_mon.timestamp_ns));
        end
        fail_count   <= fails;
        pending      <= expected_q.size();
        results_seen <= checked;
    end

endmodule

// ===== tb/trigger_image_timestamp_matcher_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the timestamp matcher testbench: clock, reset, stimulus, output pacing, verdict.
// Depends on titm_pkg, titm_tb_pkg, both channel interfaces and titm_result_checker.
module trigger_image_timestamp_matcher_unit_test;

    localparam int QUEUE_DEPTH  = 16;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_WORDS  = 140;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 400;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         cfg_we;
    logic [titm_pkg::DELAY_W-1:0] cfg_wdata;

    titm_in_if  in_word ();
    titm_out_if out_word ();

    int fail_count;
    int pending;
    int results_seen;

    int words_sent    = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    bit src_gaps      = 1'b1;
    bit sink_stalls   = 1'b1;

    logic [titm_pkg::TS_W-1:0]    now_ns;
    logic [titm_pkg::TS_W-1:0]    last_trig;
    logic [titm_pkg::TS_W-1:0]    base_ns;
    logic [titm_pkg::DELAY_W-1:0] delay_ns;

    trigger_image_timestamp_matcher_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    titm_result_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_word),
        .out_mon      (out_word),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_word.valid && in_word.ready) || (out_word.valid && out_word.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Output ready: random runs of ready and stall, or always ready
    initial
    begin : sink_pacing
        int   run_left;
        int   r;
        logic rdy;
        run_left       = 0;
        rdy            = 1'b0;
        out_word.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                if (!sink_stalls)
                begin
                    rdy      = 1'b1;
                    run_left = 1;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                    begin
                        rdy      = 1'b1;
                        run_left = $urandom_range(1, 8);
                    end
                    else if (r < 92)
                    begin
                        rdy      = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        rdy      = 1'b0;
                        run_left = $urandom_range(20, 60);
                    end
                end
            end
            run_left       = run_left - 1;
            out_word.ready <= rdy;
        end
    end

    // Gap ahead of an input word: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (!src_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Image delay after the last trigger: early, exact limit, just over, inside, far over
    function automatic logic [titm_pkg::TS_W-1:0] image_offset(
        input logic [titm_pkg::DELAY_W-1:0] d);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 14)
            return titm_pkg::TS_W'(1);
        if (r < 22)
            return titm_pkg::TS_W'(d);
        if (r < 30)
            return titm_pkg::TS_W'(d) + titm_pkg::TS_W'(1);
        if (r < 75)
            return titm_pkg::TS_W'($urandom_range(1, (d > 0) ? d : 1));
        return titm_pkg::TS_W'(d) + titm_pkg::TS_W'($urandom_range(2, d / 2 + 100));
    endfunction

    function automatic logic [titm_pkg::DELAY_W-1:0] phase_delay(input int p);
        unique case (p)
            0:       return '0;
            1:       return titm_pkg::DELAY_W'(1);
            2:       return titm_pkg::DELAY_W'(1000000000);
            3:       return {titm_pkg::DELAY_W{1'b1}};
            4:       return titm_pkg::DELAY_W'(titm_pkg::DELAY_RESET);
            5:       return titm_pkg::DELAY_W'(1000);
            default: return titm_pkg::DELAY_W'($urandom_range(1, 1000000000));
        endcase
    endfunction

    // One input word; returns in the step where it was taken, valid still high
    task automatic send_word(input logic act, input logic [titm_pkg::TS_W-1:0] ts);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_word.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word.valid        <= 1'b1;
        in_word.action       <= act;
        in_word.timestamp_ns <= ts;
        do @(posedge clk); while (!in_word.ready);
        words_sent = words_sent + 1;
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic wait_drained();
        in_word.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_delay(input logic [titm_pkg::DELAY_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used = settings_used + 1;
    endtask

    // One delay setting: flush, then trigger/image frames with some noise words
    task automatic run_phase(input int p);
        int                        start_count;
        int                        n_trig;
        int                        n_img;
        int                        k;
        int                        r;
        logic [63:0]               rnd64;
        logic [titm_pkg::TS_W-1:0] ts;
        logic [titm_pkg::TS_W-1:0] span;
        wait_drained();
        delay_ns    = phase_delay(p);
        src_gaps    = (p % 3) != 0;
        sink_stalls = (p % 4) != 1;
        write_delay(delay_ns);
        send_word(titm_tb_pkg::ACT_IMAGE, titm_tb_pkg::TS_MAX);
        rnd64       = {$urandom, $urandom};
        base_ns     = {p[0], p[1], 1'b0, rnd64[59:0]};
        now_ns      = base_ns;
        last_trig   = base_ns;
        start_count = words_sent;
        while (words_sent - start_count < PHASE_WORDS)
        begin
            rnd64 = {$urandom, $urandom};
            span  = now_ns - base_ns + titm_pkg::TS_W'(delay_ns) * 2 + 1;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise word
                r = $urandom_range(0, 3);
                if (r == 0)
                    send_word(titm_tb_pkg::ACT_IMAGE, rnd64[titm_pkg::TS_W-1:0]);
                else if (r == 1)
                    send_word(titm_tb_pkg::ACT_IMAGE,
                              base_ns + rnd64[titm_pkg::TS_W-1:0] % span);
                else
                    send_word(titm_tb_pkg::ACT_TRIGGER,
                              base_ns + rnd64[titm_pkg::TS_W-1:0] % (now_ns - base_ns + 1));
            end
            else
            begin
                r = $urandom_range(0, 99);
                n_trig = (r < 70) ? 1 : (r < 80) ? 0 : (r < 95) ? $urandom_range(2, 5)
                                                                : $urandom_range(10, 20);
                r = $urandom_range(0, 99);
                n_img = (r < 75) ? 1 : (r < 85) ? 0 : $urandom_range(2, 3);
                for (k = 0; k < n_trig; k++)
                begin
                    now_ns    = now_ns + titm_pkg::TS_W'($urandom_range(1, delay_ns / 4 + 2));
                    last_trig = now_ns;
                    send_word(titm_tb_pkg::ACT_TRIGGER, now_ns);
                end
                for (k = 0; k < n_img; k++)
                begin
                    ts = last_trig + image_offset(delay_ns);
                    send_word(titm_tb_pkg::ACT_IMAGE, ts);
                    if (ts > now_ns)
                        now_ns = ts;
                end
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        int p;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        in_word.valid        = 1'b0;
        in_word.action       = titm_tb_pkg::ACT_TRIGGER;
        in_word.timestamp_ns = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset delay limit
        send_word(titm_tb_pkg::ACT_IMAGE, titm_pkg::TS_W'(5));          // empty FIFO
        send_word(titm_tb_pkg::ACT_TRIGGER, '0);
        send_word(titm_tb_pkg::ACT_IMAGE, '0);                          // same time: too early
        // delay exactly at limit
        send_word(titm_tb_pkg::ACT_IMAGE, titm_pkg::TS_W'(titm_pkg::DELAY_RESET));
        send_word(titm_tb_pkg::ACT_TRIGGER, titm_pkg::TS_W'(100));
        // one over: stale, then empty
        send_word(titm_tb_pkg::ACT_IMAGE, titm_pkg::TS_W'(100 + titm_pkg::DELAY_RESET + 1));
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_word(titm_tb_pkg::ACT_TRIGGER, titm_pkg::TS_W'(1000000 + i * 1000));
        send_word(titm_tb_pkg::ACT_TRIGGER, titm_tb_pkg::TS_MAX);       // full FIFO drops
        send_word(titm_tb_pkg::ACT_TRIGGER, '0);
        send_word(titm_tb_pkg::ACT_IMAGE, titm_tb_pkg::TS_MAX);         // whole FIFO stale

        for (p = 0; p < NUM_PHASES; p++)
            run_phase(p);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input words over %0d delay settings, %0d result words compared",
                 words_sent, settings_used + 1, results_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
